// ----- rtl/core/quantum_barrier_sync_top_macros.svh -----
// assertion macros shared by the barrier sync checker
`ifndef QUANTUM_BARRIER_SYNC_TOP_MACROS_SVH
`define QUANTUM_BARRIER_SYNC_TOP_MACROS_SVH

// same-cycle implication, disabled while rst is high
`define QBS_ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("barrier sync check failed");

// next-cycle implication, disabled while rst is high
`define QBS_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("barrier sync check failed");

`endif

// ----- rtl/core/qbs_pkg.sv -----
// shared types and constants of the quantum barrier sync block
package qbs_pkg;

   localparam int MAX_TILES_DEF = 64;
   localparam int TILE_W = 6;
   localparam int TIME_W = 64;
   localparam int QUANTUM_W = 32;
   localparam int TILES_W = 7;
   localparam int CSR_W = 32;

   localparam logic [QUANTUM_W-1:0] QUANTUM_RST = 32'd1000;
   localparam logic [TILES_W-1:0] TILES_RST = 7'd64;

   // last step of the remainder loop, one dividend bit per step
   localparam logic [5:0] DIV_LAST = 6'd63;

   // opcodes
   localparam logic OP_WAIT = 1'b0;
   localparam logic OP_SIGNAL = 1'b1;

   // register indexes
   localparam logic CSR_QUANTUM = 1'b0;
   localparam logic CSR_TILES = 1'b1;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_EARLY,
      ST_CHK,
      ST_MIN,
      ST_CMP,
      ST_DIV,
      ST_BASE,
      ST_ADD,
      ST_REL
   } state_type;

   // request to the shared add/subtract unit
   typedef struct packed {
      logic              add;
      logic [TIME_W-1:0] a;
      logic [TIME_W-1:0] b;
   } alu_req_type;

   // configuration seen by the sequencer
   typedef struct packed {
      logic                 load;
      logic [QUANTUM_W-1:0] load_value;
      logic [QUANTUM_W-1:0] quantum;
   } cfg_type;

endpackage

// ----- rtl/core/qbs_ram.sv -----
// generic single write, single registered read memory
module qbs_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   // write port and registered read port
   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;

endmodule

// ----- rtl/core/qbs_alu.sv -----
// shared 64 bit add/subtract unit with carry or borrow out
module qbs_alu
   import qbs_pkg::*;
(
   input  alu_req_type       req,
   output logic [TIME_W:0]   res
);

   // bit TIME_W is the carry on add and the borrow (a < b) on subtract
   always_comb begin
      if (req.add) begin
         res = {1'b0, req.a} + {1'b0, req.b};
      end else begin
         res = {1'b0, req.a} - {1'b0, req.b};
      end
   end

endmodule

// ----- rtl/core/qbs_seq.sv -----
// sequencer and datapath registers of the barrier sync block
module qbs_seq
   import qbs_pkg::*;
#(
   parameter int MAX_TILES = MAX_TILES_DEF
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               start,
   output logic                               busy,
   input  logic                               req_opcode,
   input  logic [TILE_W-1:0]                  req_tile,
   input  logic [TIME_W-1:0]                  req_local_time,
   input  logic [TIME_W-1:0]                  req_running_mask,
   output logic                               rsp_strobe,
   output logic [TILE_W-1:0]                  rsp_released_tile,
   output logic                               rsp_last,
   input  cfg_type                            cfg,
   input  logic [$clog2(MAX_TILES+1)-1:0]     active_cnt,
   output alu_req_type                        alu_req,
   input  logic [TIME_W:0]                    alu_res,
   output logic                               ram_we,
   output logic [$clog2(MAX_TILES)-1:0]       ram_waddr,
   output logic [TIME_W-1:0]                  ram_wdata,
   output logic [$clog2(MAX_TILES)-1:0]       ram_raddr,
   input  logic [TIME_W-1:0]                  ram_rdata
);

   localparam int CNT_W = $clog2(MAX_TILES + 1);
   localparam int IDX_W = $clog2(MAX_TILES);

   state_type state_ff, state_in;

   logic                 op_ff, op_in;
   logic [TILE_W-1:0]    tile_ff, tile_in;
   logic [TIME_W-1:0]    time_ff, time_in;
   logic [TIME_W-1:0]    mask_ff, mask_in;
   logic [TIME_W-1:0]    barrier_ff, barrier_in;
   logic [TIME_W-1:0]    cmin_ff, cmin_in;
   logic [TIME_W-1:0]    base_ff, base_in;
   logic [QUANTUM_W-1:0] rem_ff, rem_in;
   logic [5:0]           step_ff, step_in;
   logic                 over_ff, over_in;
   logic                 any_ff, any_in;
   logic                 one_at_ff, one_at_in;
   logic                 stop_ff, stop_in;
   logic [CNT_W-1:0]     ptr_ff, ptr_in;
   logic                 ev_ff, ev_in;
   logic [IDX_W-1:0]     ev_idx_ff, ev_idx_in;
   logic                 rvld_ff, rvld_in;
   logic [MAX_TILES-1:0] valid_ff, valid_in;
   logic [MAX_TILES-1:0] wait_ff, wait_in;
   logic                 pend_ff, pend_in;
   logic [IDX_W-1:0]     pend_idx_ff, pend_idx_in;
   logic                 strobe_ff, strobe_in;
   logic [TILE_W-1:0]    out_tile_ff, out_tile_in;
   logic                 out_last_ff, out_last_in;

   logic [TIME_W-1:0]    clk_val;
   logic [QUANTUM_W-1:0] q_eff;
   logic                 issue;
   logic                 scan_end;
   logic                 borrow;
   logic [QUANTUM_W:0]   shifted;
   logic [TILE_W-1:0]    ev_tile;

   // scan pointer runs one entry ahead of the evaluated entry
   assign issue     = (ptr_ff < active_cnt);
   assign scan_end  = !ev_ff && !issue;
   assign ram_raddr = ptr_ff[IDX_W-1:0];
   assign rvld_in   = issue && valid_ff[ptr_ff[IDX_W-1:0]];
   assign clk_val   = rvld_ff ? ram_rdata : '0;
   assign q_eff     = (cfg.quantum == '0) ? QUANTUM_W'(1) : cfg.quantum;
   assign borrow    = alu_res[TIME_W];
   assign shifted   = {rem_ff, base_ff[TIME_W-1]};
   assign ev_tile   = TILE_W'(ev_idx_ff);
   assign busy      = (state_ff != ST_IDLE);

   // next state and datapath
   always_comb begin
      state_in    = state_ff;
      op_in       = op_ff;
      tile_in     = tile_ff;
      time_in     = time_ff;
      mask_in     = mask_ff;
      barrier_in  = barrier_ff;
      cmin_in     = cmin_ff;
      base_in     = base_ff;
      rem_in      = rem_ff;
      step_in     = step_ff;
      over_in     = over_ff;
      any_in      = any_ff;
      one_at_in   = one_at_ff;
      stop_in     = stop_ff;
      ptr_in      = ptr_ff;
      ev_in       = 1'b0;
      ev_idx_in   = ev_idx_ff;
      valid_in    = valid_ff;
      wait_in     = wait_ff;
      pend_in     = pend_ff;
      pend_idx_in = pend_idx_ff;
      strobe_in   = 1'b0;
      out_tile_in = out_tile_ff;
      out_last_in = out_last_ff;
      alu_req     = '0;
      ram_we      = 1'b0;
      ram_waddr   = tile_ff[IDX_W-1:0];
      ram_wdata   = time_ff;

      // scan states advance the pointer each cycle while entries remain to issue
      if (state_ff == ST_CHK || state_ff == ST_MIN || state_ff == ST_REL) begin
         ev_in     = issue;
         ev_idx_in = ptr_ff[IDX_W-1:0];
         if (issue) begin
            ptr_in = ptr_ff + CNT_W'(1);
         end
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (cfg.load) begin
               barrier_in = TIME_W'(cfg.load_value);
            end
            if (start) begin
               op_in    = req_opcode;
               tile_in  = req_tile;
               time_in  = req_local_time;
               mask_in  = req_running_mask;
               state_in = ST_EARLY;
            end
         end

         // early release, drop a wait for a tile not in use, or store the wait and start the check
         ST_EARLY: begin
            alu_req.a = time_ff;
            alu_req.b = barrier_ff;
            ptr_in    = '0;
            one_at_in = 1'b0;
            stop_in   = 1'b0;
            if (op_ff == OP_WAIT && borrow) begin
               strobe_in   = 1'b1;
               out_tile_in = tile_ff;
               out_last_in = 1'b1;
               state_in    = ST_IDLE;
            end else if (op_ff == OP_WAIT && (TILES_W'(tile_ff) >= TILES_W'(active_cnt))) begin
               state_in = ST_IDLE;
            end else begin
               if (op_ff == OP_WAIT) begin
                  ram_we = 1'b1;
                  valid_in[tile_ff[IDX_W-1:0]] = 1'b1;
                  wait_in[tile_ff[IDX_W-1:0]]  = 1'b1;
               end
               state_in = ST_CHK;
            end
         end

         // barrier check over all tiles in use
         ST_CHK: begin
            alu_req.a = clk_val;
            alu_req.b = barrier_ff;
            if (ev_ff) begin
               if (borrow) begin
                  if (mask_ff[ev_tile]) begin
                     stop_in = 1'b1;
                  end
               end else begin
                  one_at_in = 1'b1;
               end
            end
            if (scan_end) begin
               ptr_in = '0;
               any_in = 1'b0;
               if (one_at_ff && !stop_ff) begin
                  state_in = ST_MIN;
               end else begin
                  state_in = ST_IDLE;
               end
            end
         end

         // smallest clock among waiting tiles
         ST_MIN: begin
            alu_req.a = clk_val;
            alu_req.b = cmin_ff;
            if (ev_ff && wait_ff[ev_idx_ff] && (!any_ff || borrow)) begin
               cmin_in = clk_val;
               any_in  = 1'b1;
            end
            if (scan_end) begin
               state_in = any_ff ? ST_CMP : ST_IDLE;
            end
         end

         // barrier above cmin keeps its base, else reduce the distance
         ST_CMP: begin
            alu_req.a = cmin_ff;
            alu_req.b = barrier_ff;
            rem_in    = '0;
            step_in   = '0;
            if (borrow) begin
               base_in  = barrier_ff;
               state_in = ST_ADD;
            end else begin
               base_in  = alu_res[TIME_W-1:0];
               state_in = ST_DIV;
            end
         end

         // restoring remainder, one dividend bit per cycle
         ST_DIV: begin
            alu_req.a = TIME_W'(shifted);
            alu_req.b = TIME_W'(q_eff);
            rem_in    = borrow ? shifted[QUANTUM_W-1:0] : alu_res[QUANTUM_W-1:0];
            base_in   = {base_ff[TIME_W-2:0], 1'b0};
            step_in   = step_ff + 6'd1;
            if (step_ff == DIV_LAST) begin
               state_in = ST_BASE;
            end
         end

         // base = cmin minus remainder
         ST_BASE: begin
            alu_req.a = cmin_ff;
            alu_req.b = TIME_W'(rem_ff);
            base_in   = alu_res[TIME_W-1:0];
            state_in  = ST_ADD;
         end

         // new barrier one quantum above base, carry kept
         ST_ADD: begin
            alu_req.add = 1'b1;
            alu_req.a   = base_ff;
            alu_req.b   = TIME_W'(q_eff);
            barrier_in  = alu_res[TIME_W-1:0];
            over_in     = alu_res[TIME_W];
            ptr_in      = '0;
            pend_in     = 1'b0;
            state_in    = ST_REL;
         end

         // release scan, each result held back one hit to mark the last
         ST_REL: begin
            alu_req.a = clk_val;
            alu_req.b = barrier_ff;
            if (ev_ff && wait_ff[ev_idx_ff] && (over_ff || borrow)) begin
               wait_in[ev_idx_ff] = 1'b0;
               if (pend_ff) begin
                  strobe_in   = 1'b1;
                  out_tile_in = TILE_W'(pend_idx_ff);
                  out_last_in = 1'b0;
               end
               pend_in     = 1'b1;
               pend_idx_in = ev_idx_ff;
            end
            if (scan_end) begin
               if (pend_ff) begin
                  strobe_in   = 1'b1;
                  out_tile_in = TILE_W'(pend_idx_ff);
                  out_last_in = 1'b1;
               end
               pend_in  = 1'b0;
               state_in = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_IDLE;
         barrier_ff <= TIME_W'(QUANTUM_RST);
         valid_ff   <= '0;
         wait_ff    <= '0;
         ev_ff      <= 1'b0;
         pend_ff    <= 1'b0;
         strobe_ff  <= 1'b0;
      end else begin
         state_ff   <= state_in;
         barrier_ff <= barrier_in;
         valid_ff   <= valid_in;
         wait_ff    <= wait_in;
         ev_ff      <= ev_in;
         pend_ff    <= pend_in;
         strobe_ff  <= strobe_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      op_ff       <= op_in;
      tile_ff     <= tile_in;
      time_ff     <= time_in;
      mask_ff     <= mask_in;
      cmin_ff     <= cmin_in;
      base_ff     <= base_in;
      rem_ff      <= rem_in;
      step_ff     <= step_in;
      over_ff     <= over_in;
      any_ff      <= any_in;
      one_at_ff   <= one_at_in;
      stop_ff     <= stop_in;
      ptr_ff      <= ptr_in;
      ev_idx_ff   <= ev_idx_in;
      rvld_ff     <= rvld_in;
      pend_idx_ff <= pend_idx_in;
      out_tile_ff <= out_tile_in;
      out_last_ff <= out_last_in;
   end

   assign rsp_strobe        = strobe_ff;
   assign rsp_released_tile = out_tile_ff;
   assign rsp_last          = out_last_ff;

endmodule

// ----- rtl/core/quantum_barrier_sync_top.sv -----
// top level of the quantum barrier sync block
//
// An item is taken on a rising edge with start high and busy low. opcode
// OP_WAIT carries a tile and its local time; OP_SIGNAL only reruns the
// barrier check against running_mask. Each released tile shows for one
// cycle on rsp_released_tile with rsp_strobe high; rsp_last marks the
// final release of an item. The receiver cannot stall the results.
// An early release is decided in ST_EARLY. Otherwise the check scans the
// n tiles in use through the single tile clock memory read port; a
// release adds a min scan, a compare, a bit serial remainder over 64
// dividend bits on the shared 64 bit subtractor and a base step unless
// the barrier is above the smallest waiting clock, an add step and the
// release scan, with n at most 64, one item at a time while busy is high.
// Registers are written on csr_we: index 0 quantum (also loads the
// barrier time), index 1 tiles in use; write only while busy is low.
// Reset clears all waiting marks and the valid flags of the tile clocks,
// sets quantum and the barrier time to 1000 and tiles in use to 64.
module quantum_barrier_sync_top
   import qbs_pkg::*;
#(
   parameter int MAX_TILES = MAX_TILES_DEF
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   output logic                 busy,
   input  logic                 req_opcode,
   input  logic [TILE_W-1:0]    req_tile,
   input  logic [TIME_W-1:0]    req_local_time,
   input  logic [TIME_W-1:0]    req_running_mask,
   output logic                 rsp_strobe,
   output logic [TILE_W-1:0]    rsp_released_tile,
   output logic                 rsp_last,
   input  logic                 csr_we,
   input  logic                 csr_index,
   input  logic [CSR_W-1:0]     csr_wdata
);

   localparam int CNT_W = $clog2(MAX_TILES + 1);
   localparam int IDX_W = $clog2(MAX_TILES);

   logic [QUANTUM_W-1:0] quantum_ff, quantum_in;
   logic [TILES_W-1:0]   tiles_ff, tiles_in;
   logic [CNT_W-1:0]     active_cnt;
   cfg_type              cfg;
   alu_req_type          alu_req;
   logic [TIME_W:0]      alu_res;
   logic                 ram_we;
   logic [IDX_W-1:0]     ram_waddr;
   logic [TIME_W-1:0]    ram_wdata;
   logic [IDX_W-1:0]     ram_raddr;
   logic [TIME_W-1:0]    ram_rdata;

   // register writes
   always_comb begin
      quantum_in = quantum_ff;
      tiles_in   = tiles_ff;
      if (csr_we) begin
         unique case (csr_index)
            CSR_QUANTUM: quantum_in = csr_wdata[QUANTUM_W-1:0];
            CSR_TILES:   tiles_in   = csr_wdata[TILES_W-1:0];
            default:     quantum_in = quantum_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         quantum_ff <= QUANTUM_RST;
         tiles_ff   <= TILES_RST;
      end else begin
         quantum_ff <= quantum_in;
         tiles_ff   <= tiles_in;
      end
   end

   // tiles in use clipped to the array size
   assign active_cnt = (tiles_ff > TILES_W'(MAX_TILES)) ? CNT_W'(MAX_TILES)
                                                        : CNT_W'(tiles_ff);

   assign cfg.load       = csr_we && (csr_index == CSR_QUANTUM);
   assign cfg.load_value = csr_wdata[QUANTUM_W-1:0];
   assign cfg.quantum    = quantum_ff;

   qbs_seq #(
      .MAX_TILES(MAX_TILES)
   ) u_seq (
      .clock             (clock),
      .reset             (reset),
      .start             (start),
      .busy              (busy),
      .req_opcode        (req_opcode),
      .req_tile          (req_tile),
      .req_local_time    (req_local_time),
      .req_running_mask  (req_running_mask),
      .rsp_strobe        (rsp_strobe),
      .rsp_released_tile (rsp_released_tile),
      .rsp_last          (rsp_last),
      .cfg               (cfg),
      .active_cnt        (active_cnt),
      .alu_req           (alu_req),
      .alu_res           (alu_res),
      .ram_we            (ram_we),
      .ram_waddr         (ram_waddr),
      .ram_wdata         (ram_wdata),
      .ram_raddr         (ram_raddr),
      .ram_rdata         (ram_rdata)
   );

   qbs_alu u_alu (
      .req (alu_req),
      .res (alu_res)
   );

   // tile clocks
   qbs_ram #(
      .WIDTH(TIME_W),
      .DEPTH(MAX_TILES)
   ) u_clock_ram (
      .clock (clock),
      .we    (ram_we),
      .waddr (ram_waddr),
      .wdata (ram_wdata),
      .raddr (ram_raddr),
      .rdata (ram_rdata)
   );

endmodule

// ----- rtl/core/qbs_checker.sv -----
// port level checks of the barrier sync block and their bind
`include "quantum_barrier_sync_top_macros.svh"

module qbs_checker
   import qbs_pkg::*;
(
   input logic                 clock,
   input logic                 reset,
   input logic                 start,
   input logic                 busy,
   input logic                 rsp_strobe,
   input logic                 rsp_last
);

   // an accepted item makes the block busy in the next cycle
   `QBS_ASSERT_NEXT(a_accept_busy, clock, reset, start && !busy, busy)

   // more releases follow, so the block is still working
   `QBS_ASSERT_IMPL(a_mid_busy, clock, reset, rsp_strobe && !rsp_last, busy)

   // the final release shows once the block is free again
   `QBS_ASSERT_IMPL(a_last_idle, clock, reset, rsp_strobe && rsp_last, !busy)

   // reset leaves the block idle with no item shown
   `QBS_ASSERT_NEXT(a_reset_idle, clock, 1'b0, reset, !busy && !rsp_strobe)

endmodule

bind quantum_barrier_sync_top qbs_checker u_qbs_checker (.*);
